[hdl/srwt_pkg.sv]
// Shared constants, codes and types of the selective-repeat window tracker.
`timescale 1ns / 1ps
`default_nettype none
package srwt_pkg;

    localparam int MAX_FRAME_COUNT_DEF = 128;
    localparam int MAX_WINDOW = 32;
    localparam int RESULT_LIMIT = 34;
    // Delivery records stop once this many records were given for one beat.
    localparam int DLV_CAP = RESULT_LIMIT - 1;

    localparam int WIN_W = 6;
    localparam int POS_W = 8;
    localparam int OC_W = 2;
    localparam int KIND_W = 2;
    localparam int IDX_W = 7;
    localparam int CNT_W = 6;
    localparam int MAP_W = 2;
    localparam int MAP_ACK = 1;
    localparam int MAP_RCV = 0;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [WIN_W-1:0] WIN_RST = 6'd4;
    localparam logic [POS_W-1:0] TOT_RST = 8'd16;

    localparam logic [OC_W-1:0] OC_SUCCESS = 2'd0;
    localparam logic [OC_W-1:0] OC_FRAME_LOST = 2'd1;
    localparam logic [OC_W-1:0] OC_ACK_LOST = 2'd2;

    typedef enum logic {
        R_WIN,
        R_TOT
    } t_reg;

    typedef enum logic [KIND_W-1:0] {
        K_SENT,
        K_DELIVER,
        K_DONE,
        K_BAD
    } t_kind;

    typedef enum logic [1:0] {
        SEL_CURSOR,
        SEL_BASE,
        SEL_DELIVER
    } t_rsel;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN1_RD,
        S_SCAN1_CHK,
        S_SEND,
        S_SCAN2_RD,
        S_SCAN2_CHK,
        S_PASS_END,
        S_BASE_RD,
        S_BASE_CHK,
        S_DLV_RD,
        S_DLV_CHK,
        S_DONE_CHK,
        S_BAD,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic  clr_step;
        logic  take;
        logic  step_init;
        logic  rd_en;
        t_rsel rd_sel;
        logic  cur_inc;
        logic  base_inc;
        logic  dp_inc;
        logic  cur_to_pend;
        logic  send;
        logic  emit;
        t_kind kind;
        logic  flush;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic in_valid;
        logic cfg_bad;
        logic xfer_done;
        logic cur_lt_end;
        logic base_lt_total;
        logic dlv_more;
        logic rd_acked;
        logic rd_recv;
        logic stage_valid;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

[hdl/srwt_if.sv]
// Valid/ready channel interfaces for the input outcome and the output records.
`timescale 1ns / 1ps
`default_nettype none
interface srwt_in_if import srwt_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [OC_W-1:0] outcome;

    modport source(output valid, output outcome, input ready);
    modport sink(input valid, input outcome, output ready);
endinterface

interface srwt_out_if import srwt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] record_kind;
    logic [IDX_W-1:0]  frame_index;
    logic [OC_W-1:0]   sent_outcome;
    logic              last_record;

    modport source(output valid, output record_kind, output frame_index,
                   output sent_outcome, output last_record, input ready);
    modport sink(input valid, input record_kind, input frame_index,
                 input sent_outcome, input last_record, output ready);
endinterface
`default_nettype wire

[hdl/srwt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module srwt_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[hdl/srwt_ctrl.sv]
// Sequencer of the window tracker: one state per step of a beat's work.
`timescale 1ns / 1ps
`default_nettype none
module srwt_ctrl import srwt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output t_state     o_state
);

    t_state r_state;
    t_state n_state;
    logic   w_can_emit;

    // A new record may enter the stage when it is empty or its content can move on.
    assign w_can_emit = !i_stat.stage_valid || i_stat.out_free;
    assign o_state    = r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_stat.in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.cfg_bad) n_state = S_BAD;
                else if (i_stat.xfer_done) n_state = S_IDLE;
                else n_state = S_SCAN1_RD;
            end
            S_SCAN1_RD: begin
                n_state = i_stat.cur_lt_end ? S_SCAN1_CHK : S_PASS_END;
            end
            S_SCAN1_CHK: begin
                n_state = i_stat.rd_acked ? S_SCAN1_RD : S_SEND;
            end
            S_SEND: begin
                if (w_can_emit) n_state = S_SCAN2_RD;
            end
            S_SCAN2_RD: begin
                n_state = i_stat.cur_lt_end ? S_SCAN2_CHK : S_PASS_END;
            end
            S_SCAN2_CHK: begin
                n_state = i_stat.rd_acked ? S_SCAN2_RD : S_FLUSH;
            end
            S_PASS_END: begin
                n_state = S_BASE_RD;
            end
            S_BASE_RD: begin
                n_state = i_stat.base_lt_total ? S_BASE_CHK : S_DLV_RD;
            end
            S_BASE_CHK: begin
                n_state = i_stat.rd_acked ? S_BASE_RD : S_DLV_RD;
            end
            S_DLV_RD: begin
                n_state = i_stat.dlv_more ? S_DLV_CHK : S_DONE_CHK;
            end
            S_DLV_CHK: begin
                if (!i_stat.rd_recv) n_state = S_DONE_CHK;
                else if (w_can_emit) n_state = S_DLV_RD;
            end
            S_DONE_CHK: begin
                if (!i_stat.xfer_done || w_can_emit) n_state = S_FLUSH;
            end
            S_BAD: begin
                if (w_can_emit) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (!i_stat.stage_valid || i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = SEL_CURSOR;
        o_cmd.kind   = K_SENT;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                o_cmd.take = 1'b1;
            end
            S_CHECK: begin
                o_cmd.step_init = !i_stat.cfg_bad && !i_stat.xfer_done;
            end
            S_SCAN1_RD, S_SCAN2_RD: begin
                o_cmd.rd_en  = i_stat.cur_lt_end;
                o_cmd.rd_sel = SEL_CURSOR;
            end
            S_SCAN1_CHK, S_SCAN2_CHK: begin
                o_cmd.cur_inc = i_stat.rd_acked;
            end
            S_SEND: begin
                o_cmd.send    = w_can_emit;
                o_cmd.emit    = w_can_emit;
                o_cmd.cur_inc = w_can_emit;
                o_cmd.kind    = K_SENT;
            end
            S_PASS_END: begin
                o_cmd.cur_to_pend = 1'b1;
            end
            S_BASE_RD: begin
                o_cmd.rd_en  = i_stat.base_lt_total;
                o_cmd.rd_sel = SEL_BASE;
            end
            S_BASE_CHK: begin
                o_cmd.base_inc = i_stat.rd_acked;
            end
            S_DLV_RD: begin
                o_cmd.rd_en  = i_stat.dlv_more;
                o_cmd.rd_sel = SEL_DELIVER;
            end
            S_DLV_CHK: begin
                o_cmd.emit   = i_stat.rd_recv && w_can_emit;
                o_cmd.dp_inc = i_stat.rd_recv && w_can_emit;
                o_cmd.kind   = K_DELIVER;
            end
            S_DONE_CHK: begin
                o_cmd.emit = i_stat.xfer_done && w_can_emit;
                o_cmd.kind = K_DONE;
            end
            S_BAD: begin
                o_cmd.emit = w_can_emit;
                o_cmd.kind = K_BAD;
            end
            S_FLUSH: begin
                o_cmd.flush = i_stat.stage_valid && i_stat.out_free;
            end
            default: begin
                o_cmd.take = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

[hdl/srwt_dpath.sv]
// Datapath of the window tracker: pointers, frame map memory, config and record staging.
`timescale 1ns / 1ps
`default_nettype none
module srwt_dpath import srwt_pkg::*; #(
    parameter int MAX_FRAME_COUNT = MAX_FRAME_COUNT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    srwt_in_if.sink                i_in_ch,
    srwt_out_if.source             o_out_ch
);

    localparam int AW = (MAX_FRAME_COUNT > 1) ? $clog2(MAX_FRAME_COUNT) : 1;
    localparam int MAXC_W = $clog2(MAX_FRAME_COUNT + 1);
    localparam int CMP_W = (MAXC_W > POS_W) ? MAXC_W : POS_W;

    // Configuration.
    logic [WIN_W-1:0] r_win;
    logic [POS_W-1:0] r_tot;

    // Transfer state.
    logic [POS_W-1:0] r_base;
    logic [POS_W-1:0] r_dp;
    logic [POS_W-1:0] r_cursor;
    logic [POS_W-1:0] r_pend;
    logic [CNT_W-1:0] r_cnt;
    logic [AW-1:0]    r_clr_addr;
    logic [OC_W-1:0]  r_oc;

    // Record stage and output register.
    logic              r_stg_valid;
    t_kind             r_stg_kind;
    logic [IDX_W-1:0]  r_stg_idx;
    logic [OC_W-1:0]   r_stg_oc;
    logic              r_out_valid;
    logic [KIND_W-1:0] r_out_kind;
    logic [IDX_W-1:0]  r_out_idx;
    logic [OC_W-1:0]   r_out_oc;
    logic              r_out_last;

    logic [POS_W:0]    w_sum;
    logic [POS_W-1:0]  w_new_pend;
    logic [POS_W-1:0]  w_end;
    logic [IDX_W-1:0]  w_new_idx;
    logic [OC_W-1:0]   w_new_oc;
    logic              w_out_free;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [MAP_W-1:0]  w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [MAP_W-1:0]  w_rdata;
    logic              w_cfg_wr;

    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (t_reg'(paddr[2]))
            R_WIN:   prdata = APB_DW'(r_win);
            R_TOT:   prdata = APB_DW'(r_tot);
            default: prdata = '0;
        endcase
    end

    assign w_sum      = {1'b0, r_base} + (POS_W + 1)'(r_win);
    assign w_new_pend = (w_sum > {1'b0, r_tot}) ? r_tot : w_sum[POS_W-1:0];
    assign w_end      = (r_pend < r_tot) ? r_pend : r_tot;

    assign w_out_free = !r_out_valid || o_out_ch.ready;

    always_comb begin
        case (i_cmd.kind)
            K_SENT:    w_new_idx = r_cursor[IDX_W-1:0];
            K_DELIVER: w_new_idx = r_dp[IDX_W-1:0];
            default:   w_new_idx = '0;
        endcase
    end
    assign w_new_oc = (i_cmd.kind == K_SENT) ? r_oc : '0;

    // Frame map: a lost frame leaves its entry as it was.
    assign w_we = i_cmd.clr_step ||
                  (i_cmd.send && (r_oc == OC_SUCCESS || r_oc == OC_ACK_LOST));
    assign w_waddr = i_cmd.clr_step ? r_clr_addr : AW'(r_cursor);
    always_comb begin
        w_wdata = '0;
        if (!i_cmd.clr_step) begin
            w_wdata[MAP_ACK] = (r_oc == OC_SUCCESS);
            w_wdata[MAP_RCV] = 1'b1;
        end
    end

    always_comb begin
        case (i_cmd.rd_sel)
            SEL_CURSOR:  w_raddr = AW'(r_cursor);
            SEL_BASE:    w_raddr = AW'(r_base);
            SEL_DELIVER: w_raddr = AW'(r_dp);
            default:     w_raddr = AW'(r_cursor);
        endcase
    end

    srwt_ram #(
        .WIDTH(MAP_W),
        .DEPTH(MAX_FRAME_COUNT)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (i_cmd.rd_en),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= WIN_RST;
            r_tot       <= TOT_RST;
            r_base      <= '0;
            r_dp        <= '0;
            r_cursor    <= '0;
            r_pend      <= '0;
            r_cnt       <= '0;
            r_clr_addr  <= '0;
            r_stg_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (t_reg'(paddr[2]))
                    R_WIN:   r_win <= pwdata[WIN_W-1:0];
                    R_TOT:   r_tot <= pwdata[POS_W-1:0];
                    default: r_win <= r_win;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.step_init) begin
                r_cnt <= '0;
                if (r_cursor >= r_pend) begin
                    r_pend   <= w_new_pend;
                    r_cursor <= r_base;
                end
            end else if (i_cmd.cur_inc) begin
                r_cursor <= r_cursor + POS_W'(1);
            end else if (i_cmd.cur_to_pend) begin
                r_cursor <= r_pend;
            end
            if (i_cmd.base_inc) begin
                r_base <= r_base + POS_W'(1);
            end
            if (i_cmd.dp_inc) begin
                r_dp <= r_dp + POS_W'(1);
            end
            if (i_cmd.emit) begin
                r_cnt       <= r_cnt + CNT_W'(1);
                r_stg_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_stg_valid <= 1'b0;
            end
            if ((i_cmd.emit && r_stg_valid) || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_cmd.take) begin
            r_oc <= i_in_ch.outcome;
        end
        if ((i_cmd.emit && r_stg_valid) || i_cmd.flush) begin
            r_out_kind <= r_stg_kind;
            r_out_idx  <= r_stg_idx;
            r_out_oc   <= r_stg_oc;
            r_out_last <= i_cmd.flush;
        end
        if (i_cmd.emit) begin
            r_stg_kind <= i_cmd.kind;
            r_stg_idx  <= w_new_idx;
            r_stg_oc   <= w_new_oc;
        end
    end

    assign i_in_ch.ready         = i_cmd.take;
    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.record_kind  = r_out_kind;
    assign o_out_ch.frame_index  = r_out_idx;
    assign o_out_ch.sent_outcome = r_out_oc;
    assign o_out_ch.last_record  = r_out_last;

    always_comb begin
        o_stat.clear_last    = (r_clr_addr == AW'(MAX_FRAME_COUNT - 1));
        o_stat.in_valid      = i_in_ch.valid;
        o_stat.cfg_bad       = (r_win == '0) || (r_win > WIN_W'(MAX_WINDOW)) ||
                               (r_tot == '0) ||
                               (CMP_W'(r_tot) > CMP_W'(MAX_FRAME_COUNT)) ||
                               (POS_W'(r_win) > r_tot);
        o_stat.xfer_done     = (r_dp >= r_tot);
        o_stat.cur_lt_end    = (r_cursor < w_end);
        o_stat.base_lt_total = (r_base < r_tot);
        o_stat.dlv_more      = (r_dp < r_tot) && (r_cnt < CNT_W'(DLV_CAP));
        o_stat.rd_acked      = w_rdata[MAP_ACK];
        o_stat.rd_recv       = w_rdata[MAP_RCV];
        o_stat.stage_valid   = r_stg_valid;
        o_stat.out_free      = w_out_free;
    end

endmodule
`default_nettype wire

[hdl/selective_repeat_window_tracker_unit.sv]
// Top level of the selective-repeat window tracker: sequencer, datapath and checks.
//
// Usage: the sender's scoreboard of a selective-repeat transfer. Each beat on
// i_in_ch carries the outcome of the next frame that the sender transmits
// (success, frame lost, ack lost). For each beat the block gives zero or more
// record beats on o_out_ch: a sent record for the frame, then at the end of a
// window pass the in-order delivery records and a done record once every frame
// is delivered. The final record caused by a beat has last_record set. With an
// invalid window or frame count each beat gives one invalid-config record.
// Window size and frame count sit in two APB registers (0x0 and 0x4); write
// them only while the block is idle.
// Timing: each map lookup takes a read state and then a check state, because the
// map has a registered read. A mid-pass beat keeps the block busy through its send
// and the scan past acked frames, and no new beat is taken before that ends. Ending a
// pass also slides the base over acked frames and gives the delivery records.
// Reset: after i_rst_n is released the map memory is cleared one entry a cycle,
// every entry in turn, while i_in_ch.ready stays low.
// Stalls: one staged record plus an output register decouple the block from
// the receiver; the block simply waits while o_out_ch.ready is low, and takes
// the next input beat while the last record of a beat is still held.
`timescale 1ns / 1ps
`default_nettype none
module selective_repeat_window_tracker_unit import srwt_pkg::*; #(
    parameter int MAX_FRAME_COUNT = MAX_FRAME_COUNT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    srwt_in_if.sink                i_in_ch,
    srwt_out_if.source             o_out_ch
);

    t_cmd   w_cmd;
    t_stat  w_stat;
    t_state w_state;

    // Register writes always complete in their access cycle.
    assign pready = 1'b1;

    srwt_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (w_stat),
        .o_cmd  (w_cmd),
        .o_state(w_state)
    );

    srwt_dpath #(
        .MAX_FRAME_COUNT(MAX_FRAME_COUNT)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_in_ch (i_in_ch),
        .o_out_ch(o_out_ch)
    );

    // The memory clear runs right after reset, so no beat is taken then.
    a_no_take_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ch.ready && w_state == S_CLEAR)
        else $error("input taken during map clear");

    // Every record of the previous beat has left the stage before a new beat.
    a_stage_empty_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ch.ready |-> !w_stat.stage_valid)
        else $error("stage holds a record while a new beat is taken");

    // A done record always closes the records of its beat.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.record_kind == K_DONE) |-> o_out_ch.last_record)
        else $error("done record without last marker");

    // An invalid-config record is a lone, empty record.
    a_bad_record_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.record_kind == K_BAD) |->
            (o_out_ch.last_record && o_out_ch.frame_index == '0 &&
             o_out_ch.sent_outcome == '0))
        else $error("malformed invalid-config record");

endmodule
`default_nettype wire
